// ----- rtl/core/mss_pkg.sv -----
package mss_pkg;

  localparam int SAMPLE_BITS = 12;

  localparam int QUIET_BITS = 7;
  localparam int RUN_BITS   = 3;
  localparam int TIME_BITS  = 64;
  localparam int DELAY_BITS = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int QUIET_MAX = 100;
  localparam int RUN_LIMIT = 4;

  localparam int DEBOUNCE_RESET = 50;
  localparam int RECOVERY_RESET = 5000000;
  localparam int WINDOW_RESET   = 5000000;
  localparam int CENTER_RESET   = 1960;
  localparam int BAND_RESET     = 200;

  typedef enum logic [1:0] {
    OP_SAMPLE      = 2'd0,
    OP_CAL_STEP    = 2'd1,
    OP_CAL_RESTART = 2'd2
  } op_t;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_DEBOUNCE = 3'd0;
  localparam cfg_index_t CFG_RECOVERY = 3'd1;
  localparam cfg_index_t CFG_WINDOW   = 3'd2;
  localparam cfg_index_t CFG_CENTER   = 3'd3;
  localparam cfg_index_t CFG_BAND     = 3'd4;

endpackage

// ----- rtl/core/mains_sense_qualifier.sv -----
// Mains sense qualifier: one beat in, one beat out, at up to one beat per clock. Each input
// beat is captured in an input register, processed in a single pass by the qualifier
// state logic (peak/trough, wave direction, quiet run, active status with recovery delay,
// dc offset calibration) and its result lands in an output register; while a result
// waits on m_axis_tready the input register can still take one more beat, after which
// s_axis_tready drops until the result is taken.
// Operation codes on s_axis_tuser: 0 sample, 1 calibration step, 2 restart calibration,
// 3 no change. A start time of 0 means "not started". Configuration writes take effect at
// once and are meant for when the block is idle.
module mains_sense_qualifier #(
  parameter int SAMPLE_BITS = mss_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_code, now_us
  input  logic [((SAMPLE_BITS + mss_pkg::TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // operation
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // source_active, wave_up, peak_code, trough_code, quiet_count, calibrated, dc_offset
  output logic [((3 * SAMPLE_BITS + mss_pkg::QUIET_BITS + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // offset_valid
  output logic                               m_axis_tuser,
  input  logic                               cfg_we,
  input  mss_pkg::cfg_index_t                cfg_index,
  input  logic [mss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int TB       = mss_pkg::TIME_BITS;
  localparam int QB       = mss_pkg::QUIET_BITS;
  localparam int IN_BITS  = SAMPLE_BITS + TB;
  localparam int OUT_BITS = 3 * SAMPLE_BITS + QB + 4;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic                   in_valid;
  mss_pkg::op_t           in_op;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TB-1:0]          in_now;
  logic                   advance;

  logic [QB-1:0]                     debounce_samples;
  logic [mss_pkg::DELAY_BITS-1:0]    recovery_delay_us;
  logic [mss_pkg::DELAY_BITS-1:0]    calibration_window_us;
  logic [SAMPLE_BITS-1:0]            center_code;
  logic [SAMPLE_BITS-1:0]            quiet_band;

  logic                   res_active;
  logic                   res_wave_up;
  logic [SAMPLE_BITS-1:0] res_peak;
  logic [SAMPLE_BITS:0]   res_trough;
  logic [QB-1:0]          res_quiet;
  logic                   res_calibrated;
  logic [SAMPLE_BITS-1:0] res_offset;
  logic                   res_offset_valid;

  logic                   out_active;
  logic                   out_wave_up;
  logic [SAMPLE_BITS-1:0] out_peak;
  logic [SAMPLE_BITS:0]   out_trough;
  logic [QB-1:0]          out_quiet;
  logic                   out_calibrated;
  logic [SAMPLE_BITS-1:0] out_offset;
  logic                   out_offset_valid;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op     <= mss_pkg::op_t'(s_axis_tuser);
      in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_now    <= s_axis_tdata[IN_BITS-1:SAMPLE_BITS];
    end
  end

  mss_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .debounce_samples      (debounce_samples),
    .recovery_delay_us     (recovery_delay_us),
    .calibration_window_us (calibration_window_us),
    .center_code           (center_code),
    .quiet_band            (quiet_band)
  );

  mss_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk                   (clk),
    .rst                   (rst),
    .fire                  (advance),
    .op                    (in_op),
    .sample_code           (in_sample),
    .now_us                (in_now),
    .debounce_samples      (debounce_samples),
    .recovery_delay_us     (recovery_delay_us),
    .calibration_window_us (calibration_window_us),
    .center_code           (center_code),
    .quiet_band            (quiet_band),
    .source_active         (res_active),
    .wave_up               (res_wave_up),
    .peak_code             (res_peak),
    .trough_code           (res_trough),
    .quiet_count           (res_quiet),
    .calibrated            (res_calibrated),
    .dc_offset             (res_offset),
    .offset_valid          (res_offset_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_active       <= res_active;
      out_wave_up      <= res_wave_up;
      out_peak         <= res_peak;
      out_trough       <= res_trough;
      out_quiet        <= res_quiet;
      out_calibrated   <= res_calibrated;
      out_offset       <= res_offset;
      out_offset_valid <= res_offset_valid;
    end
  end

  assign m_axis_tdata = OUT_W'({out_offset, out_calibrated, out_quiet, out_trough,
                                out_peak, out_wave_up, out_active});
  assign m_axis_tuser = out_offset_valid;

endmodule

// ----- rtl/core/mss_cfg.sv -----
module mss_cfg #(
  parameter int SAMPLE_BITS = mss_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  mss_pkg::cfg_index_t                 cfg_index,
  input  logic [mss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [mss_pkg::QUIET_BITS-1:0]      debounce_samples,
  output logic [mss_pkg::DELAY_BITS-1:0]      recovery_delay_us,
  output logic [mss_pkg::DELAY_BITS-1:0]      calibration_window_us,
  output logic [SAMPLE_BITS-1:0]              center_code,
  output logic [SAMPLE_BITS-1:0]              quiet_band
);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_samples      <= mss_pkg::QUIET_BITS'(mss_pkg::DEBOUNCE_RESET);
      recovery_delay_us     <= mss_pkg::DELAY_BITS'(mss_pkg::RECOVERY_RESET);
      calibration_window_us <= mss_pkg::DELAY_BITS'(mss_pkg::WINDOW_RESET);
      center_code           <= SAMPLE_BITS'(mss_pkg::CENTER_RESET);
      quiet_band            <= SAMPLE_BITS'(mss_pkg::BAND_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        mss_pkg::CFG_DEBOUNCE: begin
          debounce_samples <= cfg_data[mss_pkg::QUIET_BITS-1:0];
        end
        mss_pkg::CFG_RECOVERY: begin
          recovery_delay_us <= cfg_data[mss_pkg::DELAY_BITS-1:0];
        end
        mss_pkg::CFG_WINDOW: begin
          calibration_window_us <= cfg_data[mss_pkg::DELAY_BITS-1:0];
        end
        mss_pkg::CFG_CENTER: begin
          center_code <= cfg_data[SAMPLE_BITS-1:0];
        end
        mss_pkg::CFG_BAND: begin
          quiet_band <= cfg_data[SAMPLE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/mss_core.sv -----
module mss_core #(
  parameter int SAMPLE_BITS = mss_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  mss_pkg::op_t                       op,
  input  logic [SAMPLE_BITS-1:0]             sample_code,
  input  logic [mss_pkg::TIME_BITS-1:0]      now_us,
  input  logic [mss_pkg::QUIET_BITS-1:0]     debounce_samples,
  input  logic [mss_pkg::DELAY_BITS-1:0]     recovery_delay_us,
  input  logic [mss_pkg::DELAY_BITS-1:0]     calibration_window_us,
  input  logic [SAMPLE_BITS-1:0]             center_code,
  input  logic [SAMPLE_BITS-1:0]             quiet_band,
  output logic                               source_active,
  output logic                               wave_up,
  output logic [SAMPLE_BITS-1:0]             peak_code,
  output logic [SAMPLE_BITS:0]               trough_code,
  output logic [mss_pkg::QUIET_BITS-1:0]     quiet_count,
  output logic                               calibrated,
  output logic [SAMPLE_BITS-1:0]             dc_offset,
  output logic                               offset_valid
);

  localparam int TB = mss_pkg::TIME_BITS;
  localparam int QB = mss_pkg::QUIET_BITS;
  localparam int RB = mss_pkg::RUN_BITS;
  localparam logic [SAMPLE_BITS:0] TROUGH_NONE = {1'b1, {SAMPLE_BITS{1'b0}}};

  logic                   active_flag,     active_flag_next;
  logic [TB-1:0]          recovery_start,  recovery_start_next;
  logic [SAMPLE_BITS-1:0] peak_reg,        peak_reg_next;
  logic [SAMPLE_BITS:0]   trough_reg,      trough_reg_next;
  logic [RB-1:0]          rise_run,        rise_run_next;
  logic [RB-1:0]          fall_run,        fall_run_next;
  logic                   direction_up,    direction_up_next;
  logic [QB-1:0]          quiet_run,       quiet_run_next;
  logic [SAMPLE_BITS-1:0] previous_sample, previous_sample_next;
  logic [SAMPLE_BITS-1:0] latest_sample,   latest_sample_next;
  logic                   calibrated_flag, calibrated_flag_next;
  logic [TB-1:0]          window_start,    window_start_next;

  logic [SAMPLE_BITS-1:0] center_gap;
  logic [RB-1:0]          rise_inc;
  logic [RB-1:0]          fall_inc;
  logic [QB-1:0]          quiet_new;
  logic [TB-1:0]          rec_elapsed;
  logic                   want_active;
  logic [TB-1:0]          ws_eff;
  logic [SAMPLE_BITS-1:0] pk_eff;
  logic [SAMPLE_BITS:0]   tr_eff;
  logic [TB-1:0]          win_elapsed;
  logic [SAMPLE_BITS+1:0] mid_sum;
  logic [SAMPLE_BITS-1:0] offset;
  logic                   valid;

  // sample path terms
  always_comb begin
    center_gap = (sample_code >= center_code) ? sample_code - center_code
                                              : center_code - sample_code;
    rise_inc = rise_run + RB'(1);
    fall_inc = fall_run + RB'(1);
    if (center_gap < quiet_band) begin
      quiet_new = (quiet_run < QB'(mss_pkg::QUIET_MAX)) ? quiet_run + QB'(1) : quiet_run;
    end else begin
      quiet_new = '0;
    end
    want_active = quiet_new < debounce_samples;
    rec_elapsed = now_us - recovery_start;
  end

  // calibration path terms
  always_comb begin
    if (window_start == '0) begin
      ws_eff = now_us;
      pk_eff = '0;
      tr_eff = TROUGH_NONE;
    end else begin
      ws_eff = window_start;
      pk_eff = peak_reg;
      tr_eff = trough_reg;
    end
    win_elapsed = now_us - ws_eff;
    mid_sum     = {2'b00, pk_eff} + {1'b0, tr_eff};
  end

  always_comb begin
    active_flag_next     = active_flag;
    recovery_start_next  = recovery_start;
    peak_reg_next        = peak_reg;
    trough_reg_next      = trough_reg;
    rise_run_next        = rise_run;
    fall_run_next        = fall_run;
    direction_up_next    = direction_up;
    quiet_run_next       = quiet_run;
    previous_sample_next = previous_sample;
    latest_sample_next   = latest_sample;
    calibrated_flag_next = calibrated_flag;
    window_start_next    = window_start;
    offset               = '0;
    valid                = 1'b0;

    case (op)
      mss_pkg::OP_SAMPLE: begin
        latest_sample_next   = sample_code;
        previous_sample_next = sample_code;
        if (sample_code > peak_reg) peak_reg_next = sample_code;
        if ({1'b0, sample_code} < trough_reg) trough_reg_next = {1'b0, sample_code};
        if (sample_code > previous_sample) begin
          rise_run_next = rise_inc;
        end else begin
          fall_run_next = fall_inc;
        end
        if (rise_run_next > RB'(mss_pkg::RUN_LIMIT)) begin
          direction_up_next = 1'b1;
          rise_run_next     = '0;
          fall_run_next     = '0;
        end else if (fall_run_next > RB'(mss_pkg::RUN_LIMIT)) begin
          direction_up_next = 1'b0;
          rise_run_next     = '0;
          fall_run_next     = '0;
        end
        quiet_run_next = quiet_new;
        if (want_active) begin
          if (recovery_start == '0) begin
            recovery_start_next = now_us;
          end else if (rec_elapsed >= {{(TB-mss_pkg::DELAY_BITS){1'b0}}, recovery_delay_us}) begin
            active_flag_next    = 1'b1;
            recovery_start_next = '0;
          end
        end else begin
          active_flag_next    = 1'b0;
          recovery_start_next = '0;
        end
      end
      mss_pkg::OP_CAL_STEP: begin
        if (!calibrated_flag) begin
          if (win_elapsed < {{(TB-mss_pkg::DELAY_BITS){1'b0}}, calibration_window_us}) begin
            window_start_next = ws_eff;
            peak_reg_next     = (latest_sample > pk_eff) ? latest_sample : pk_eff;
            trough_reg_next   = ({1'b0, latest_sample} < tr_eff) ? {1'b0, latest_sample}
                                                                 : tr_eff;
          end else begin
            peak_reg_next        = pk_eff;
            trough_reg_next      = tr_eff;
            offset               = mid_sum[SAMPLE_BITS:1];
            valid                = 1'b1;
            calibrated_flag_next = 1'b1;
            window_start_next    = '0;
          end
        end
      end
      mss_pkg::OP_CAL_RESTART: begin
        calibrated_flag_next = 1'b0;
        window_start_next    = '0;
        peak_reg_next        = '0;
        trough_reg_next      = TROUGH_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag     <= 1'b0;
      recovery_start  <= '0;
      peak_reg        <= '0;
      trough_reg      <= TROUGH_NONE;
      rise_run        <= '0;
      fall_run        <= '0;
      direction_up    <= 1'b0;
      quiet_run       <= '0;
      previous_sample <= '0;
      latest_sample   <= '0;
      calibrated_flag <= 1'b0;
      window_start    <= '0;
    end else if (fire) begin
      active_flag     <= active_flag_next;
      recovery_start  <= recovery_start_next;
      peak_reg        <= peak_reg_next;
      trough_reg      <= trough_reg_next;
      rise_run        <= rise_run_next;
      fall_run        <= fall_run_next;
      direction_up    <= direction_up_next;
      quiet_run       <= quiet_run_next;
      previous_sample <= previous_sample_next;
      latest_sample   <= latest_sample_next;
      calibrated_flag <= calibrated_flag_next;
      window_start    <= window_start_next;
    end
  end

  assign source_active = active_flag_next;
  assign wave_up       = direction_up_next;
  assign peak_code     = peak_reg_next;
  assign trough_code   = trough_reg_next;
  assign quiet_count   = quiet_run_next;
  assign calibrated    = calibrated_flag_next;
  assign dc_offset     = offset;
  assign offset_valid  = valid;

endmodule

// ----- dv/tb_mains_sense_qualifier.sv -----
module tb_mains_sense_qualifier;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 80;
  localparam int OUT_W = 48;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [12:0] TROUGH_NONE = 13'd4096;
  localparam logic [11:0] CODE_MAX    = 12'hFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] sample_code;
    logic [63:0] stamp;
  } beat_t;

  typedef struct packed {
    logic        active;
    logic        wave_up;
    logic [11:0] peak;
    logic [12:0] trough;
    logic [6:0]  quiet;
    logic        calibrated;
    logic [11:0] offset;
    logic        offset_valid;
  } status_t;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_we;
  mss_pkg::cfg_index_t cfg_index;
  logic [mss_pkg::CFG_DATA_BITS-1:0] cfg_data;

  // register mirror
  logic [6:0]  cf_debounce;
  logic [31:0] cf_recovery;
  logic [31:0] cf_window;
  logic [11:0] cf_center;
  logic [11:0] cf_band;

  // qualifier state mirror
  logic        q_active;
  logic [63:0] q_recovery_start;
  logic [11:0] q_peak;
  logic [12:0] q_trough;
  logic [2:0]  q_rise;
  logic [2:0]  q_fall;
  logic        q_dir_up;
  logic [6:0]  q_quiet;
  logic [11:0] q_prev;
  logic [11:0] q_latest;
  logic        q_calibrated;
  logic [63:0] q_window_start;

  beat_t   pending_beats[$];
  status_t expected_status[$];
  beat_t   held_beat;
  int      beats_queued;
  int      results_seen;
  int      error_count;
  logic    calm;

  mains_sense_qualifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic fold_extremes(input logic [11:0] code);
    if (code > q_peak) q_peak = code;
    if ({1'b0, code} < q_trough) q_trough = {1'b0, code};
  endtask

  task automatic qualify_beat(input beat_t b);
    status_t     r;
    logic [11:0] gap;
    logic [13:0] mid;
    r = '0;
    case (b.op)
      mss_pkg::OP_SAMPLE: begin
        q_latest = b.sample_code;
        fold_extremes(b.sample_code);
        if (b.sample_code > q_prev) q_rise = q_rise + 3'd1;
        else q_fall = q_fall + 3'd1;
        if (q_rise > mss_pkg::RUN_LIMIT) begin
          q_dir_up = 1'b1;
          q_rise   = '0;
          q_fall   = '0;
        end
        if (q_fall > mss_pkg::RUN_LIMIT) begin
          q_dir_up = 1'b0;
          q_rise   = '0;
          q_fall   = '0;
        end
        gap = (b.sample_code >= cf_center) ? b.sample_code - cf_center
                                           : cf_center - b.sample_code;
        if (gap < cf_band) begin
          if (q_quiet < mss_pkg::QUIET_MAX) q_quiet = q_quiet + 7'd1;
        end else begin
          q_quiet = '0;
        end
        q_prev = b.sample_code;
        // active request waits out the recovery delay, inactive is immediate
        if (q_quiet >= cf_debounce) begin
          q_active         = 1'b0;
          q_recovery_start = '0;
        end else if (q_recovery_start == '0) begin
          q_recovery_start = b.stamp;
        end else if ((b.stamp - q_recovery_start) >= {32'd0, cf_recovery}) begin
          q_active         = 1'b1;
          q_recovery_start = '0;
        end
      end
      mss_pkg::OP_CAL_STEP: begin
        if (!q_calibrated) begin
          if (q_window_start == '0) begin
            q_window_start = b.stamp;
            q_peak         = '0;
            q_trough       = TROUGH_NONE;
          end
          if ((b.stamp - q_window_start) < {32'd0, cf_window}) begin
            fold_extremes(q_latest);
          end else begin
            mid            = ({2'b00, q_peak} + {1'b0, q_trough}) >> 1;
            r.offset       = mid[11:0];
            r.offset_valid = 1'b1;
            q_calibrated   = 1'b1;
            q_window_start = '0;
          end
        end
      end
      mss_pkg::OP_CAL_RESTART: begin
        q_calibrated   = 1'b0;
        q_window_start = '0;
        q_peak         = '0;
        q_trough       = TROUGH_NONE;
      end
      default: begin
      end
    endcase
    r.active     = q_active;
    r.wave_up    = q_dir_up;
    r.peak       = q_peak;
    r.trough     = q_trough;
    r.quiet      = q_quiet;
    r.calibrated = q_calibrated;
    expected_status.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) qualify_beat(held_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          held_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, held_beat.stamp, held_beat.sample_code};
          s_axis_tuser  <= held_beat.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          $error("result beat with no expectation pending");
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("source_active", 64'(want.active),       64'(m_axis_tdata[0]));
          check_field("wave_up",       64'(want.wave_up),      64'(m_axis_tdata[1]));
          check_field("peak_code",     64'(want.peak),         64'(m_axis_tdata[13:2]));
          check_field("trough_code",   64'(want.trough),       64'(m_axis_tdata[26:14]));
          check_field("quiet_count",   64'(want.quiet),        64'(m_axis_tdata[33:27]));
          check_field("calibrated",    64'(want.calibrated),   64'(m_axis_tdata[34]));
          check_field("dc_offset",     64'(want.offset),       64'(m_axis_tdata[46:35]));
          check_field("offset_valid",  64'(want.offset_valid), 64'(m_axis_tuser));
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [11:0] code,
                           input logic [63:0] stamp);
    beat_t b;
    b.op          = op;
    b.sample_code = code;
    b.stamp       = stamp;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic write_reg(input mss_pkg::cfg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      mss_pkg::CFG_DEBOUNCE: cf_debounce = value[6:0];
      mss_pkg::CFG_RECOVERY: cf_recovery = value;
      mss_pkg::CFG_WINDOW:   cf_window   = value;
      mss_pkg::CFG_CENTER:   cf_center   = value[11:0];
      mss_pkg::CFG_BAND:     cf_band     = value[11:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_registers(input logic [31:0] debounce, input logic [31:0] recovery,
                               input logic [31:0] window, input logic [31:0] center,
                               input logic [31:0] band);
    while (results_seen != beats_queued) @(posedge clk);
    write_reg(mss_pkg::CFG_DEBOUNCE, debounce);
    write_reg(mss_pkg::CFG_RECOVERY, recovery);
    write_reg(mss_pkg::CFG_WINDOW, window);
    write_reg(mss_pkg::CFG_CENTER, center);
    write_reg(mss_pkg::CFG_BAND, band);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_phase(input int count, input int stride_max, input logic [63:0] base);
    logic [63:0] clock_us;
    logic [1:0]  op;
    int          mode;
    int          run_left;
    int          level;
    int          ramp_level;
    bit          ramp_rising;
    int          roll;
    int          band;
    clock_us    = base;
    run_left    = 0;
    mode        = 0;
    level       = 0;
    ramp_level  = $urandom_range(0, 4095);
    ramp_rising = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      if ($urandom_range(0, 99) == 0) clock_us = {$urandom, $urandom};
      else clock_us = clock_us + 64'($urandom_range(0, stride_max));
      roll = $urandom_range(0, 99);
      if (roll < 84) op = mss_pkg::OP_SAMPLE;
      else if (roll < 94) op = mss_pkg::OP_CAL_STEP;
      else if (roll < 98) op = mss_pkg::OP_CAL_RESTART;
      else op = OP_UNUSED;
      case (mode)
        0: begin
          // near the centre level
          band  = int'(cf_band);
          level = int'(cf_center);
          if (band > 0) level = level + $urandom_range(0, band - 1) *
                                ($urandom_range(0, 1) ? 1 : -1);
        end
        1: begin
          if (ramp_rising) ramp_level = ramp_level + $urandom_range(1, 250);
          else ramp_level = ramp_level - $urandom_range(1, 250);
          if (ramp_level >= 4095) ramp_rising = 1'b0;
          if (ramp_level <= 0) ramp_rising = 1'b1;
          level = ramp_level;
        end
        2: level = $urandom_range(0, 4095);
        default: begin
          if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 1) ? 4095 : 0;
        end
      endcase
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      push_beat(op, 12'(level), clock_us);
    end
  endtask

  initial begin
    logic [63:0] base;
    rst           = 1'b1;
    calm          = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = mss_pkg::CFG_DEBOUNCE;
    cfg_data      = '0;
    beats_queued  = 0;
    results_seen  = 0;
    error_count   = 0;

    cf_debounce      = 7'(mss_pkg::DEBOUNCE_RESET);
    cf_recovery      = 32'(mss_pkg::RECOVERY_RESET);
    cf_window        = 32'(mss_pkg::WINDOW_RESET);
    cf_center        = 12'(mss_pkg::CENTER_RESET);
    cf_band          = 12'(mss_pkg::BAND_RESET);
    q_active         = 1'b0;
    q_recovery_start = '0;
    q_peak           = '0;
    q_trough         = TROUGH_NONE;
    q_rise           = '0;
    q_fall           = '0;
    q_dir_up         = 1'b0;
    q_quiet          = '0;
    q_prev           = '0;
    q_latest         = '0;
    q_calibrated     = 1'b0;
    q_window_start   = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    set_registers(3, 100, 50, 2000, 100);
    push_beat(OP_UNUSED, 12'hABC, 64'd0);
    push_beat(mss_pkg::OP_SAMPLE, 12'd0, 64'd0);
    push_beat(mss_pkg::OP_SAMPLE, CODE_MAX, 64'd1);
    push_beat(mss_pkg::OP_SAMPLE, CODE_MAX, 64'd101);
    push_beat(mss_pkg::OP_SAMPLE, 12'd100, 64'd102);
    push_beat(mss_pkg::OP_SAMPLE, 12'd1000, 64'd103);
    push_beat(mss_pkg::OP_SAMPLE, 12'd2000, 64'd104);
    push_beat(mss_pkg::OP_SAMPLE, 12'd3000, 64'd105);
    push_beat(mss_pkg::OP_SAMPLE, CODE_MAX, 64'd106);
    push_beat(mss_pkg::OP_SAMPLE, 12'd2000, 64'd110);
    push_beat(mss_pkg::OP_SAMPLE, 12'd2050, 64'd111);
    push_beat(mss_pkg::OP_SAMPLE, 12'd1901, 64'd112);
    push_beat(mss_pkg::OP_SAMPLE, 12'd2100, 64'd120);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'd0);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'd130);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'd179);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'd180);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'd200);
    push_beat(mss_pkg::OP_CAL_RESTART, 12'd0, 64'd210);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'hFFFF_FFFF_FFFF_FFF0);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'h5);
    push_beat(mss_pkg::OP_CAL_STEP, 12'd0, 64'h40);
    push_beat(mss_pkg::OP_CAL_RESTART, 12'd0, 64'h41);
    push_beat(mss_pkg::OP_SAMPLE, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) push_beat(mss_pkg::OP_SAMPLE, 12'd2000, 64'h50 + 64'(i));
    push_beat(mss_pkg::OP_SAMPLE, CODE_MAX, 64'hFFFF_FFFF_FFFF_FFF0);
    push_beat(mss_pkg::OP_SAMPLE, 12'd0, 64'h10);
    push_beat(mss_pkg::OP_SAMPLE, CODE_MAX, 64'h70);

    // random phases
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_registers(mss_pkg::DEBOUNCE_RESET, mss_pkg::RECOVERY_RESET,
                         mss_pkg::WINDOW_RESET, mss_pkg::CENTER_RESET,
                         mss_pkg::BAND_RESET);
        1: set_registers(0, 0, 0, 0, 4095);
        2: set_registers(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095, 0);
        3: set_registers(1, 1, 1, 2048, 1);
        default: set_registers($urandom_range(1, 12), $urandom_range(0, 3000),
                               $urandom_range(0, 3000), $urandom_range(0, 4095),
                               $urandom_range(0, 600));
      endcase
      calm = (p == 2);
      base = {$urandom, $urandom};
      if (p == 3) base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 200));
      case (p)
        0: fill_phase(240, 60000, base);
        1: fill_phase(240, 5, base);
        2: fill_phase(240, 1000, base);
        3: fill_phase(240, 3, base);
        default: fill_phase(235, $urandom_range(1, 400), base);
      endcase
    end

    while (results_seen != beats_queued) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected results never arrived", expected_status.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- mains_sense_qualifier.f -----
rtl/core/mss_pkg.sv
rtl/core/mss_cfg.sv
rtl/core/mss_core.sv
rtl/core/mains_sense_qualifier.sv
dv/tb_mains_sense_qualifier.sv
